// ===== rtl/nlbs_pkg.sv =====
// ----------------------------------------------------------------------------
// nlbs_pkg: shared types and constants for the nearest light box selector
// Table size, result count, field widths, opcodes and facing codes.
// ----------------------------------------------------------------------------
package nlbs_pkg;

    localparam int MaxLights = 64;
    localparam int Keep      = 8;
    localparam int IdxW      = $clog2(MaxLights);
    localparam int TotW      = $clog2(MaxLights + 1);
    localparam int SlotW     = $clog2(Keep);
    localparam int BestW     = $clog2(Keep + 1);
    localparam int CoordW    = 24;
    localparam int RadW      = 20;
    localparam int DistW     = 50;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] FAC_NEG_X = 3'd1;
    localparam logic [2:0] FAC_POS_X = 3'd2;
    localparam logic [2:0] FAC_NEG_Y = 3'd3;
    localparam logic [2:0] FAC_POS_Y = 3'd4;
    localparam logic [2:0] FAC_NEG_Z = 3'd5;
    localparam logic [2:0] FAC_POS_Z = 3'd6;

    typedef logic signed [CoordW-1:0] t_coord;

    // One stored light as read from the table.
    typedef struct packed {
        t_coord             px;
        t_coord             py;
        t_coord             pz;
        logic [RadW-1:0]    reach;
        logic [2:0]         facing;
    } t_light;

    // Candidate handed from the test unit to the sorter.
    typedef struct packed {
        logic               valid;
        logic [DistW-1:0]   sq_dist;
        logic [IdxW-1:0]    index;
    } t_cand;

endpackage

// ===== rtl/nearest_light_box_selector.sv =====
// ----------------------------------------------------------------------------
// nearest_light_box_selector: k nearest point lights for a query box
// Stores lights in a table; a query culls each light and keeps the nearest.
// ----------------------------------------------------------------------------
//  channel | direction | beats per item
//  in      | input     | one
//  out     | output    | add: one, query: Keep, clear: none
//
//  A query walks the table one light at a time: a read and a test state, then
//  for a kept light three steps on the shared squarer in the wait state; a
//  culled light skips them. Results follow one per cycle while the output is
//  not stalled. o_stall is high while busy and while an output beat is
//  stalled; a stalled beat holds. Reset empties the table; the stored
//  entries need no clearing.
// ----------------------------------------------------------------------------
module nearest_light_box_selector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic signed [23:0]            i_pos_x,
    input  logic signed [23:0]            i_pos_y,
    input  logic signed [23:0]            i_pos_z,
    input  logic signed [23:0]            i_lo_x,
    input  logic signed [23:0]            i_lo_y,
    input  logic signed [23:0]            i_lo_z,
    input  logic signed [23:0]            i_hi_x,
    input  logic signed [23:0]            i_hi_y,
    input  logic signed [23:0]            i_hi_z,
    input  logic [19:0]                   i_radius,
    input  logic [2:0]                    i_facing,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_slot,
    output logic [5:0]                    o_light_index,
    output logic                          o_hit,
    output logic                          o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]                       r_state;
    logic [nlbs_pkg::TotW-1:0]        r_total;
    logic [nlbs_pkg::IdxW-1:0]        r_n;
    logic [nlbs_pkg::SlotW-1:0]       r_slot;
    nlbs_pkg::t_coord                 r_cx, r_cy, r_cz, r_lx, r_ly, r_lz, r_hx, r_hy, r_hz;
    nlbs_pkg::t_light                 r_mem [nlbs_pkg::MaxLights];
    nlbs_pkg::t_light                 r_rd;
    nlbs_pkg::t_cand                  w_cand;
    logic                             w_busy;
    logic [nlbs_pkg::IdxW-1:0]        w_rd_index;
    logic                             w_rd_hit;
    logic                             w_acc;
    logic                             w_oacc;
    logic                             w_add_ok;

    assign o_stall  = (r_state != S_IDLE) || (o_valid && i_stall);
    assign w_acc    = i_valid && !o_stall;
    assign w_oacc   = o_valid && !i_stall;
    assign w_add_ok = (i_radius != '0) && (r_total < nlbs_pkg::TotW'(nlbs_pkg::MaxLights));

    // light table
    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == nlbs_pkg::OP_ADD && w_add_ok) begin
            r_mem[r_total[nlbs_pkg::IdxW-1:0]] <= '{i_pos_x, i_pos_y, i_pos_z, i_radius, i_facing};
        end
        r_rd <= r_mem[r_n];
    end

    nlbs_test u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_TEST),
        .i_light (r_rd),
        .i_index (r_n),
        .i_cx (r_cx), .i_cy (r_cy), .i_cz (r_cz),
        .i_lx (r_lx), .i_ly (r_ly), .i_lz (r_lz),
        .i_hx (r_hx), .i_hy (r_hy), .i_hz (r_hz),
        .o_busy  (w_busy),
        .o_cand  (w_cand)
    );

    nlbs_sort u_sort (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_acc && i_opcode == nlbs_pkg::OP_QUERY),
        .i_cand     (w_cand),
        .i_rd_slot  (r_slot),
        .o_rd_index (w_rd_index),
        .o_rd_hit   (w_rd_hit)
    );

    // capture the query box on every accepted command
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cx <= i_pos_x; r_cy <= i_pos_y; r_cz <= i_pos_z;
            r_lx <= i_lo_x;  r_ly <= i_lo_y;  r_lz <= i_lo_z;
            r_hx <= i_hi_x;  r_hy <= i_hi_y;  r_hz <= i_hi_z;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            o_valid <= 1'b0;
            r_n     <= '0;
            r_slot  <= '0;
        end else begin
            if (w_oacc) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_opcode)
                            nlbs_pkg::OP_CLEAR: r_total <= '0;
                            nlbs_pkg::OP_ADD: begin
                                o_valid       <= 1'b1;
                                o_slot        <= '0;
                                o_last        <= 1'b1;
                                o_hit         <= w_add_ok;
                                o_light_index <= w_add_ok ? r_total[nlbs_pkg::IdxW-1:0] : '0;
                                if (w_add_ok) begin
                                    r_total <= r_total + 1'b1;
                                end
                            end
                            nlbs_pkg::OP_QUERY: begin
                                r_n    <= '0;
                                r_slot <= '0;
                                r_state <= (r_total == '0) ? S_EMIT : S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: r_state <= S_TEST;
                S_TEST: r_state <= S_WAIT;
                S_WAIT: begin
                    if (!w_busy) begin
                        if (nlbs_pkg::TotW'(r_n) + 1'b1 >= r_total) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_n <= r_n + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_EMIT: begin
                    if (!o_valid || w_oacc) begin
                        o_valid       <= 1'b1;
                        o_slot        <= r_slot;
                        o_light_index <= w_rd_index;
                        o_hit         <= w_rd_hit;
                        o_last        <= r_slot == nlbs_pkg::SlotW'(nlbs_pkg::Keep - 1);
                        r_slot        <= r_slot + 1'b1;
                        if (r_slot == nlbs_pkg::SlotW'(nlbs_pkg::Keep - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/nlbs_test.sv =====
// ----------------------------------------------------------------------------
// nlbs_test: per-light cull and distance unit
// Each call tests one light against the query box; for a light that passes, a three
// step sequence squares one axis difference a step on the shared multiplier.
// ----------------------------------------------------------------------------
module nlbs_test (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  nlbs_pkg::t_light             i_light,
    input  logic [nlbs_pkg::IdxW-1:0]    i_index,
    input  nlbs_pkg::t_coord             i_cx,
    input  nlbs_pkg::t_coord             i_cy,
    input  nlbs_pkg::t_coord             i_cz,
    input  nlbs_pkg::t_coord             i_lx,
    input  nlbs_pkg::t_coord             i_ly,
    input  nlbs_pkg::t_coord             i_lz,
    input  nlbs_pkg::t_coord             i_hx,
    input  nlbs_pkg::t_coord             i_hy,
    input  nlbs_pkg::t_coord             i_hz,
    output logic                         o_busy,
    output nlbs_pkg::t_cand              o_cand
);

    logic [1:0]                     r_step;
    logic                           r_act;
    logic                           r_keep;
    nlbs_pkg::t_light               r_lt;
    logic [nlbs_pkg::IdxW-1:0]      r_idx;
    logic [nlbs_pkg::DistW-1:0]     r_acc;
    logic signed [24:0]             w_diff;
    logic signed [49:0]             w_prod;
    logic [49:0]                    w_sq;
    logic                           w_miss;
    logic                           w_cull;
    logic signed [25:0]             w_lo_x, w_hi_x, w_lo_y, w_hi_y, w_lo_z, w_hi_z;

    // cube bounds per axis
    always_comb begin
        w_lo_x = 26'(i_light.px) - 26'(signed'({1'b0, i_light.reach}));
        w_hi_x = 26'(i_light.px) + 26'(signed'({1'b0, i_light.reach}));
        w_lo_y = 26'(i_light.py) - 26'(signed'({1'b0, i_light.reach}));
        w_hi_y = 26'(i_light.py) + 26'(signed'({1'b0, i_light.reach}));
        w_lo_z = 26'(i_light.pz) - 26'(signed'({1'b0, i_light.reach}));
        w_hi_z = 26'(i_light.pz) + 26'(signed'({1'b0, i_light.reach}));
        w_miss = (w_hi_x < 26'(i_lx)) || (w_lo_x > 26'(i_hx))
              || (w_hi_y < 26'(i_ly)) || (w_lo_y > 26'(i_hy))
              || (w_hi_z < 26'(i_lz)) || (w_lo_z > 26'(i_hz));
        case (i_light.facing)
            nlbs_pkg::FAC_NEG_X: w_cull = i_lx > i_light.px;
            nlbs_pkg::FAC_POS_X: w_cull = i_hx < i_light.px;
            nlbs_pkg::FAC_NEG_Y: w_cull = i_ly > i_light.py;
            nlbs_pkg::FAC_POS_Y: w_cull = i_hy < i_light.py;
            nlbs_pkg::FAC_NEG_Z: w_cull = i_lz > i_light.pz;
            nlbs_pkg::FAC_POS_Z: w_cull = i_hz < i_light.pz;
            default:             w_cull = 1'b0;
        endcase
    end

    // select the axis difference for this step and square it at full width
    always_comb begin
        case (r_step)
            2'd0:    w_diff = 25'(r_lt.px) - 25'(i_cx);
            2'd1:    w_diff = 25'(r_lt.py) - 25'(i_cy);
            default: w_diff = 25'(r_lt.pz) - 25'(i_cz);
        endcase
        w_prod = 50'(w_diff) * 50'(w_diff);
        w_sq   = $unsigned(w_prod);
    end

    // sequence the three squaring steps
    always_ff @(posedge i_clk) begin
        o_cand.valid <= 1'b0;
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_step <= 2'd0;
        end else if (i_start) begin
            r_lt  <= i_light;
            r_idx <= i_index;
            r_keep <= !(w_miss || w_cull);
            r_act <= !(w_miss || w_cull);
            r_step <= 2'd0;
            r_acc <= '0;
        end else if (r_act) begin
            r_acc <= r_acc + w_sq;
            if (r_step == 2'd2) begin
                r_act <= 1'b0;
                o_cand.valid   <= r_keep;
                o_cand.sq_dist <= r_acc + w_sq;
                o_cand.index   <= r_idx;
            end
            r_step <= r_step + 2'd1;
        end
    end

    assign o_busy = r_act;

endmodule

// ===== rtl/nlbs_sort.sv =====
// ----------------------------------------------------------------------------
// nlbs_sort: nearest-first result list
// Inserts one candidate per beat into a short sorted list; ties stay in order.
// ----------------------------------------------------------------------------
module nlbs_sort (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  nlbs_pkg::t_cand               i_cand,
    input  logic [nlbs_pkg::SlotW-1:0]    i_rd_slot,
    output logic [nlbs_pkg::IdxW-1:0]     o_rd_index,
    output logic                          o_rd_hit
);

    logic [nlbs_pkg::DistW-1:0]   r_dist [nlbs_pkg::Keep];
    logic [nlbs_pkg::IdxW-1:0]    r_idx  [nlbs_pkg::Keep];
    logic [nlbs_pkg::BestW-1:0]   r_total;
    logic [nlbs_pkg::Keep-1:0]    w_gt;

    // entries farther than the candidate, or unused ones, move down
    always_comb begin
        for (int k = 0; k < nlbs_pkg::Keep; k++) begin
            w_gt[k] = (nlbs_pkg::BestW'(k) >= r_total) || (r_dist[k] > i_cand.sq_dist);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_total <= '0;
        end else if (i_cand.valid) begin
            if (r_total != nlbs_pkg::BestW'(nlbs_pkg::Keep)) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // shift and insert
    always_ff @(posedge i_clk) begin
        if (i_cand.valid) begin
            for (int k = 0; k < nlbs_pkg::Keep; k++) begin
                if (w_gt[k]) begin
                    if (k == 0 || !w_gt[(k == 0) ? 0 : k - 1]) begin
                        r_dist[k] <= i_cand.sq_dist;
                        r_idx[k]  <= i_cand.index;
                    end else begin
                        r_dist[k] <= r_dist[(k == 0) ? 0 : k - 1];
                        r_idx[k]  <= r_idx[(k == 0) ? 0 : k - 1];
                    end
                end
            end
        end
    end

    assign o_rd_hit   = nlbs_pkg::BestW'(i_rd_slot) < r_total;
    assign o_rd_index = o_rd_hit ? r_idx[i_rd_slot] : '0;

endmodule
